// ===== design/gcl_pkg.sv =====
// Package for the glyph code lookup unit: field widths, beat types and defaults.
// No dependencies; used by glyph_code_lookup_unit.

package gcl_pkg;

   // Field widths of the request, response and control register
   localparam int INDEX_W = 12;
   localparam int CODE_W  = 16;
   localparam int COUNT_W = 13;

   // Default table depth
   localparam int MAX_GLYPHS_DEF = 4096;

   // Request actions
   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_LOOKUP = 1'b1;

   typedef struct packed {
      logic               action;
      logic [INDEX_W-1:0] entry_index;
      logic [CODE_W-1:0]  code;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] glyph_index;
      logic               found;
   } rsp_type;

endpackage

// ===== design/glyph_code_lookup_unit.sv =====
// Glyph code lookup unit top level: code table RAM, search sequencer, control register.
// Depends on gcl_pkg and gcl_ram.

// A write beat (action 0) stores its code at entry_index and gives no
// response; indexes at or above MAX_GLYPHS are dropped. A lookup beat
// (action 1) runs a binary search over entries 0..entry_count-1 with one
// table read per cycle, the table RAM's single port setting the pace. If
// it misses, a linear scan follows at one entry per cycle. The response
// strobe rsp_valid is high for exactly one cycle and cannot be held off;
// busy drops in that same cycle, so the next beat may start while the
// response is shown. With entry_count 0 the response follows the start
// cycle at once. Entries must be written before a lookup can read them;
// the table has no reset. The user must write entry_count only while busy
// is low; the block itself does not enforce it.

module glyph_code_lookup_unit #(
   parameter int MAX_GLYPHS = gcl_pkg::MAX_GLYPHS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  gcl_pkg::req_type             req_item,
   output logic                         rsp_valid,
   output gcl_pkg::rsp_type             rsp_item,
   input  logic                         csr_wr_en,
   input  logic [gcl_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int AW = $clog2(MAX_GLYPHS);
   localparam int NW = (gcl_pkg::COUNT_W > AW + 1) ? gcl_pkg::COUNT_W : AW + 1;
   localparam logic [NW-1:0] MAX_N = NW'(MAX_GLYPHS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_BIN  = 2'd1;
   localparam logic [1:0] S_LIN  = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [NW-1:0]                   lo_ff, lo_in;
   logic [NW-1:0]                   hx_ff, hx_in;
   logic [NW-1:0]                   mid_ff, mid_in;
   logic [NW-1:0]                   n_ff, n_in;
   logic [gcl_pkg::CODE_W-1:0]      code_ff, code_in;
   logic [gcl_pkg::COUNT_W-1:0]     count_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   gcl_pkg::rsp_type                rsp_ff, rsp_in;

   logic [gcl_pkg::CODE_W-1:0]      rd_data;
   logic                            ram_we;
   logic [NW-1:0]                   lo_step, hx_step, mid_next;
   logic [NW:0]                     mid_sum;
   logic [NW-1:0]                   n_start;
   logic [NW-1:0]                   count_ext;
   logic                            hit;

   // Control register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Count in use saturates at the table depth
   assign count_ext = NW'(count_ff);
   assign n_start   = (count_ext > MAX_N) ? MAX_N : count_ext;

   // Binary step: narrow the window around the probed entry
   assign hit     = (rd_data == code_ff);
   assign lo_step = (rd_data < code_ff) ? mid_ff + NW'(1) : lo_ff;
   assign hx_step = (rd_data < code_ff) ? hx_ff : mid_ff;
   assign mid_sum = {1'b0, lo_step} + {1'b0, hx_step} - (NW + 1)'(1);
   assign mid_next = mid_sum[NW:1];

   // Search sequencer
   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hx_in        = hx_ff;
      mid_in       = mid_ff;
      n_in         = n_ff;
      code_in      = code_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      ram_we       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            mid_in = NW'(req_item.entry_index);
            if (start) begin
               if (req_item.action == gcl_pkg::ACT_WRITE) begin
                  ram_we = (NW'(req_item.entry_index) < MAX_N);
               end else begin
                  code_in = req_item.code;
                  n_in    = n_start;
                  lo_in   = '0;
                  hx_in   = n_start;
                  if (n_start == '0) begin
                     rsp_valid_in         = 1'b1;
                     rsp_in.glyph_index   = '0;
                     rsp_in.found         = 1'b0;
                  end else begin
                     mid_in   = (n_start - NW'(1)) >> 1;
                     state_in = S_BIN;
                  end
               end
            end
         end
         S_BIN: begin
            if (hit) begin
               rsp_valid_in       = 1'b1;
               rsp_in.glyph_index = mid_ff[gcl_pkg::INDEX_W-1:0];
               rsp_in.found       = 1'b1;
               state_in           = S_IDLE;
            end else if (lo_step < hx_step) begin
               lo_in  = lo_step;
               hx_in  = hx_step;
               mid_in = mid_next;
            end else begin
               mid_in   = '0;
               state_in = S_LIN;
            end
         end
         S_LIN: begin
            if (hit) begin
               rsp_valid_in       = 1'b1;
               rsp_in.glyph_index = mid_ff[gcl_pkg::INDEX_W-1:0];
               rsp_in.found       = 1'b1;
               state_in           = S_IDLE;
            end else if (mid_ff + NW'(1) < n_ff) begin
               mid_in = mid_ff + NW'(1);
            end else begin
               rsp_valid_in       = 1'b1;
               rsp_in.glyph_index = '0;
               rsp_in.found       = 1'b0;
               state_in           = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Search payload registers
   always_ff @(posedge clock) begin
      lo_ff   <= lo_in;
      hx_ff   <= hx_in;
      mid_ff  <= mid_in;
      n_ff    <= n_in;
      code_ff <= code_in;
      rsp_ff  <= rsp_in;
   end

   // Code table; the address is the next probe, or the write index when idle
   gcl_ram #(
      .WIDTH (gcl_pkg::CODE_W),
      .DEPTH (MAX_GLYPHS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (mid_in[AW-1:0]),
      .wr_data (req_item.code),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Checks
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) ||
                     ($past(start) && $past(req_item.action) == gcl_pkg::ACT_LOOKUP)))
      else $error("response beat without a lookup in flight");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.found) |-> (rsp_item.glyph_index == '0))
      else $error("miss response with nonzero index");

   a_bin_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BIN) |-> (lo_ff <= mid_ff && mid_ff < hx_ff && hx_ff <= n_ff))
      else $error("binary search probe outside window");

   a_lin_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LIN) |-> (mid_ff < n_ff))
      else $error("linear scan past entry count");

endmodule

// ===== design/gcl_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
// No dependencies; used by glyph_code_lookup_unit for the code table.

module gcl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read share the one address
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
